FILE: rtl/nested_range_count_defines.svh
// Assertion helpers for the checker file.
`ifndef NESTED_RANGE_COUNT_DEFINES_SVH
`define NESTED_RANGE_COUNT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NRC_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("nested_range_count check failed");

// Next-cycle implication, disabled during reset.
`define NRC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("nested_range_count check failed");

`endif

FILE: rtl/nrc_pkg.sv
`timescale 1ns / 1ps

package nrc_pkg;

    localparam int MAX_RANGES = 64;
    localparam int COORD_BITS = 32;
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    // Fixed field widths of the channels
    localparam int FIELD_W    = 32;
    localparam int RES_W      = 6;

    typedef struct packed {
        logic load;     // input item taken this cycle
        logic rd_ref;   // read the reference range at index i
        logic cap_ref;  // latch reference range, clear tallies, rewind j
        logic scan;     // read entry j and advance j
        logic next_i;   // advance to the next reference range
        logic finish;   // empty the set
    } nrc_cmd_t;

    typedef struct packed {
        logic full;
        logic j_last;
        logic i_last;
    } nrc_stat_t;

endpackage

FILE: rtl/nrc_range_if.sv
`timescale 1ns / 1ps

interface nrc_range_if;
    logic                       valid;
    logic                       ready;
    logic [nrc_pkg::FIELD_W-1:0] range_start;
    logic [nrc_pkg::FIELD_W-1:0] range_end;
    logic                       is_last;

    modport source (output valid, output range_start, output range_end, output is_last,
                    input ready);
    modport sink   (input valid, input range_start, input range_end, input is_last,
                    output ready);
endinterface

FILE: rtl/nrc_result_if.sv
`timescale 1ns / 1ps

interface nrc_result_if;
    logic                      valid;
    logic                      ready;
    logic [nrc_pkg::RES_W-1:0] contains_count;
    logic [nrc_pkg::RES_W-1:0] contained_count;
    logic                      overflowed;
    logic                      last_result;

    modport source (output valid, output contains_count, output contained_count,
                    output overflowed, output last_result, input ready);
    modport sink   (input valid, input contains_count, input contained_count,
                    input overflowed, input last_result, output ready);
endinterface

FILE: rtl/nested_range_count.sv
`timescale 1ns / 1ps

// Containment counter for a set of up to 64 closed ranges. Ranges load one per
// cycle; a range that arrives with the store full is dropped and the set's
// overflowed flag is raised. The item marked is_last closes the set, after which
// one result per stored range comes out in load order, and no input is taken
// until the last result of the set has gone. Every range is compared against
// every stored range through the single read port of the range store, one
// compare per cycle while a scan runs; an output stall holds the next scan.
module nested_range_count (
    input  logic               clk,
    input  logic               rst_n,
    nrc_range_if.sink          range_in,
    nrc_result_if.source       result_out
);

    nrc_pkg::nrc_cmd_t  cmd;
    nrc_pkg::nrc_stat_t stat;

    nrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (range_in.valid),
        .in_last   (range_in.is_last),
        .in_ready  (range_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    nrc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .range_start     (range_in.range_start),
        .range_end       (range_in.range_end),
        .contains_count  (result_out.contains_count),
        .contained_count (result_out.contained_count),
        .overflowed      (result_out.overflowed),
        .last_result     (result_out.last_result)
    );

endmodule

FILE: rtl/nrc_ctrl.sv
`timescale 1ns / 1ps

module nrc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  nrc_pkg::nrc_stat_t stat,
    output nrc_pkg::nrc_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_LOAD    = 6'b000001,
        ST_REF_RD  = 6'b000010,
        ST_REF_CAP = 6'b000100,
        ST_SCAN    = 6'b001000,
        ST_DRAIN   = 6'b010000,
        ST_OUT     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = ST_REF_RD;
                    end
                end
            end
            ST_REF_RD:
            begin
                cmd.rd_ref = 1'b1;
                state_next = ST_REF_CAP;
            end
            ST_REF_CAP:
            begin
                cmd.cap_ref = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.j_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last compare lands this cycle
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.i_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.next_i = 1'b1;
                        state_next = ST_REF_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/nrc_datapath.sv
`timescale 1ns / 1ps

module nrc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nrc_pkg::nrc_cmd_t           cmd,
    output nrc_pkg::nrc_stat_t          stat,
    input  logic [nrc_pkg::FIELD_W-1:0] range_start,
    input  logic [nrc_pkg::FIELD_W-1:0] range_end,
    output logic [nrc_pkg::RES_W-1:0]   contains_count,
    output logic [nrc_pkg::RES_W-1:0]   contained_count,
    output logic                        overflowed,
    output logic                        last_result
);

    localparam int CB = nrc_pkg::COORD_BITS;
    localparam int IW = nrc_pkg::IDX_W;
    localparam int CW = nrc_pkg::CNT_W;

    // {start, end} per entry
    logic [2*CB-1:0] mem [nrc_pkg::MAX_RANGES];

    logic [CW-1:0]          count_reg;
    logic                   ovf_reg;
    logic [IW-1:0]          i_reg;
    logic [IW-1:0]          j_reg;
    logic                   rd_vld_reg;
    logic [IW-1:0]          rd_idx_reg;
    logic [2*CB-1:0]        rd_data_reg;
    logic [CB-1:0]          ref_s_reg;
    logic [CB-1:0]          ref_e_reg;
    logic [nrc_pkg::RES_W-1:0] inside_reg;
    logic [nrc_pkg::RES_W-1:0] around_reg;

    logic [IW-1:0] rd_addr;
    logic          rd_en;
    logic [CB-1:0] cur_s;
    logic [CB-1:0] cur_e;
    logic          hit_inside;
    logic          hit_around;
    logic          counted;

    assign stat.full   = (count_reg == CW'(nrc_pkg::MAX_RANGES));
    assign stat.j_last = ((CW'(j_reg) + CW'(1)) == count_reg);
    assign stat.i_last = ((CW'(i_reg) + CW'(1)) == count_reg);

    assign rd_addr = cmd.scan ? j_reg : i_reg;
    assign rd_en   = cmd.scan | cmd.rd_ref;

    assign cur_s      = rd_data_reg[2*CB-1:CB];
    assign cur_e      = rd_data_reg[CB-1:0];
    assign hit_inside = (cur_s >= ref_s_reg) && (cur_e <= ref_e_reg);
    assign hit_around = (cur_s <= ref_s_reg) && (cur_e >= ref_e_reg);
    assign counted    = rd_vld_reg && (rd_idx_reg != i_reg);

    // Range store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load && !stat.full)
        begin
            mem[count_reg[IW-1:0]] <= {range_start[CB-1:0], range_end[CB-1:0]};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        rd_idx_reg <= j_reg;
        if (cmd.cap_ref)
        begin
            ref_s_reg <= cur_s;
            ref_e_reg <= cur_e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            rd_vld_reg <= 1'b0;
            inside_reg <= '0;
            around_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            if (cmd.load)
            begin
                i_reg <= '0;
                if (stat.full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.finish)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.next_i)
            begin
                i_reg <= i_reg + IW'(1);
            end
            if (cmd.cap_ref)
            begin
                j_reg      <= '0;
                inside_reg <= '0;
                around_reg <= '0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    j_reg <= j_reg + IW'(1);
                end
                if (counted)
                begin
                    inside_reg <= inside_reg + nrc_pkg::RES_W'(hit_inside);
                    around_reg <= around_reg + nrc_pkg::RES_W'(hit_around);
                end
            end
        end
    end

    assign contains_count  = inside_reg;
    assign contained_count = around_reg;
    assign overflowed      = ovf_reg;
    assign last_result     = stat.i_last;

endmodule

FILE: rtl/nrc_checker.sv
`timescale 1ns / 1ps
`include "nested_range_count_defines.svh"

module nrc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      in_last,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [nrc_pkg::RES_W-1:0] contains_count,
    input logic [nrc_pkg::RES_W-1:0] contained_count,
    input logic                      overflowed,
    input logic                      last_result
);

    logic [2*nrc_pkg::RES_W+1:0] res_bus;
    logic                        in_take;
    logic                        out_take;

    assign res_bus  = {contains_count, contained_count, overflowed, last_result};
    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    `NRC_ASSERT_NEXT(a_res_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(res_bus))
    `NRC_ASSERT_NOW(a_no_load_while_out, clk, rst_n, out_valid, !in_ready)
    `NRC_ASSERT_NEXT(a_set_ends, clk, rst_n, out_take && last_result, !out_valid)
    `NRC_ASSERT_NEXT(a_quiet_mid_set, clk, rst_n, in_take && !in_last, !out_valid)

endmodule

bind nested_range_count nrc_checker u_nrc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (range_in.valid),
    .in_ready        (range_in.ready),
    .in_last         (range_in.is_last),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .contains_count  (result_out.contains_count),
    .contained_count (result_out.contained_count),
    .overflowed      (result_out.overflowed),
    .last_result     (result_out.last_result)
);
